@@ design/rpfl_pkg.sv @@
// package of the record pool: sizes, codes and the queue entry type
`default_nettype none

package rpfl_pkg;

  localparam int unsigned StoreWordsDef = 1024;
  localparam int unsigned MaxFieldsDef  = 8;
  localparam int unsigned RecordLimit   = 1024;
  localparam int unsigned IdxW          = 10;
  localparam int unsigned CountW        = 11;
  localparam int unsigned FieldW        = 3;
  localparam int unsigned ValueW        = 32;
  localparam int unsigned CfgW          = 4;
  localparam int unsigned QueueDepth    = 2;

  typedef enum logic [2:0] {
    MODE_GET       = 3'd0,
    MODE_SET       = 3'd1,
    MODE_PUSH_BACK = 3'd2,
    MODE_POP_BACK  = 3'd3,
    MODE_INSERT    = 3'd4,
    MODE_ERASE     = 3'd5,
    MODE_CLEAR     = 3'd6
  } mode_e;

  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_FULL = 2'd1,
    STATUS_BAD  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ST_EXEC = 2'd0,
    ST_READ = 2'd1,
    ST_LINK = 2'd2
  } back_state_e;

  // classified operation handed from front to back
  typedef struct packed {
    mode_e             mode;
    logic [IdxW-1:0]   record_index;
    logic              field_ok;
    logic              in_store;
    logic [ValueW-1:0] write_value;
  } op_t;

endpackage

`default_nettype wire

@@ design/rpfl_req_if.sv @@
// request channel of the record pool
`default_nettype none

interface rpfl_req_if;
  import rpfl_pkg::*;

  logic              valid;
  logic              ready;
  logic [2:0]        mode;
  logic [IdxW-1:0]   record_index;
  logic [FieldW-1:0] field_index;
  logic [ValueW-1:0] write_value;

  modport source (output valid, output mode, output record_index, output field_index,
                  output write_value, input ready);
  modport sink (input valid, input mode, input record_index, input field_index,
                input write_value, output ready);
endinterface

`default_nettype wire

@@ design/rpfl_rsp_if.sv @@
// response channel of the record pool
`default_nettype none

interface rpfl_rsp_if;
  import rpfl_pkg::*;

  logic              valid;
  logic              ready;
  logic [ValueW-1:0] read_value;
  logic [IdxW-1:0]   slot;
  logic [CountW-1:0] record_count;
  logic [1:0]        status;

  modport source (output valid, output read_value, output slot, output record_count,
                  output status, input ready);
  modport sink (input valid, input read_value, input slot, input record_count,
                input status, output ready);
endinterface

`default_nettype wire

@@ design/record_pool_with_free_list.sv @@
// Record pool with a free list threaded through field 0 of erased records.
// Requests arrive on req_i (valid/ready): mode, record_index, field_index and
// write_value. Each request gives exactly one response on rsp_o (valid/ready)
// with read_value, slot, record_count and status, in request order.
// fields_per_record is written through cfg_we_i / cfg_wdata_i while idle;
// the user is bound to this, the block itself does not enforce it.
// Each request passes the queue register, then the response register; get and
// free-list insert also hold the back end until the registered read of the
// single ram port returns. Throughput: one request a cycle for set, push_back,
// pop_back, erase and clear while the receiver does not stall.
// A two-entry queue sits between front and back, so requests keep being
// taken while the back waits on the ram or on a stalled receiver.
// A stalled receiver holds the response register; the back end stops, then
// the queue fills and req_i.ready drops.
// Reset empties the queue, the record count and the free list, and sets
// fields_per_record to one; word store contents are not cleared.
`default_nettype none

module record_pool_with_free_list #(
  parameter int unsigned StoreWords = rpfl_pkg::StoreWordsDef,
  parameter int unsigned MaxFields  = rpfl_pkg::MaxFieldsDef
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [rpfl_pkg::CfgW-1:0] cfg_wdata_i,
  rpfl_req_if.sink                       req_i,
  rpfl_rsp_if.source                     rsp_o
);
  import rpfl_pkg::*;

  localparam int unsigned FieldCntW = $clog2(MaxFields + 1);
  localparam int unsigned SpanAw    = $clog2(RecordLimit * MaxFields);
  localparam int unsigned RamAw     = $clog2(StoreWords);
  localparam int unsigned WordAw    = (SpanAw > RamAw) ? SpanAw : RamAw;

  // configuration register, raw value as written
  logic [CfgW-1:0]      fields_q;
  // effective field count: zero acts as one, large values clamp
  logic [FieldCntW-1:0] fields_eff;

  // front to back queue output
  logic              op_valid, op_ready;
  op_t               op;
  logic [WordAw-1:0] op_addr;

  // word store port
  logic              ram_we;
  logic [RamAw-1:0]  ram_addr;
  logic [ValueW-1:0] ram_wdata, ram_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fields_q <= CfgW'(1);
    end else if (cfg_we_i) begin
      fields_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    if (fields_q == '0) begin
      fields_eff = FieldCntW'(1);
    end else if (32'(fields_q) > MaxFields) begin
      fields_eff = FieldCntW'(MaxFields);
    end else begin
      fields_eff = FieldCntW'(fields_q);
    end
  end

  // front: classification and address arithmetic, then the queue
  rpfl_front #(
    .StoreWords (StoreWords),
    .MaxFields  (MaxFields)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fields_i   (fields_eff),
    .req_i      (req_i),
    .op_valid_o (op_valid),
    .op_ready_i (op_ready),
    .op_o       (op),
    .op_addr_o  (op_addr)
  );

  // back: count, free list head and the response register
  rpfl_back #(
    .StoreWords (StoreWords),
    .MaxFields  (MaxFields)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fields_i    (fields_eff),
    .op_valid_i  (op_valid),
    .op_ready_o  (op_ready),
    .op_i        (op),
    .op_addr_i   (op_addr),
    .rsp_o       (rsp_o),
    .ram_we_o    (ram_we),
    .ram_addr_o  (ram_addr),
    .ram_wdata_o (ram_wdata),
    .ram_rdata_i (ram_rdata)
  );

  // flat word store, records laid out field after field
  rpfl_ram #(
    .Width (ValueW),
    .Depth (StoreWords)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

endmodule

`default_nettype wire

@@ design/rpfl_ram.sv @@
// generic single-port ram with registered read
`default_nettype none

module rpfl_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024,
  localparam int unsigned Aw = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [Aw-1:0]    addr_i,
  input  wire logic [Width-1:0] wdata_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

`default_nettype wire

@@ design/rpfl_front.sv @@
// front of the record pool: accepts requests, works out word addresses, queues them
`default_nettype none

module rpfl_front #(
  parameter int unsigned StoreWords = rpfl_pkg::StoreWordsDef,
  parameter int unsigned MaxFields  = rpfl_pkg::MaxFieldsDef,
  localparam int unsigned FieldCntW = $clog2(MaxFields + 1),
  localparam int unsigned SpanAw    = $clog2(rpfl_pkg::RecordLimit * MaxFields),
  localparam int unsigned RamAw     = $clog2(StoreWords),
  localparam int unsigned WordAw    = (SpanAw > RamAw) ? SpanAw : RamAw
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic [FieldCntW-1:0] fields_i,
  rpfl_req_if.sink                  req_i,
  output logic                      op_valid_o,
  input  wire logic                 op_ready_i,
  output rpfl_pkg::op_t             op_o,
  output logic      [WordAw-1:0]    op_addr_o
);
  import rpfl_pkg::*;

  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;

  op_t               op_q   [QueueDepth];
  logic [WordAw-1:0] addr_q [QueueDepth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;

  op_t               new_op;
  logic [WordAw-1:0] base, new_addr;
  logic              push, pop;

  // classification: base word of the record, field word, range flags
  always_comb begin
    base     = WordAw'(req_i.record_index) * WordAw'(fields_i);
    new_addr = (mode_e'(req_i.mode) == MODE_ERASE) ? base
                                                   : base + WordAw'(req_i.field_index);
    new_op.mode         = mode_e'(req_i.mode);
    new_op.record_index = req_i.record_index;
    new_op.field_ok     = 32'(req_i.field_index) < 32'(fields_i);
    new_op.in_store     = 32'(new_addr) < StoreWords;
    new_op.write_value  = req_i.write_value;
  end

  assign req_i.ready = (cnt_q != CntW'(QueueDepth));
  assign push        = req_i.valid && req_i.ready;
  assign op_valid_o  = (cnt_q != '0);
  assign pop         = op_valid_o && op_ready_i;
  assign op_o        = op_q[rd_ptr_q];
  assign op_addr_o   = addr_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (32'(wr_ptr_q) == QueueDepth - 1) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (32'(rd_ptr_q) == QueueDepth - 1) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      op_q[wr_ptr_q]   <= new_op;
      addr_q[wr_ptr_q] <= new_addr;
    end
  end

endmodule

`default_nettype wire

@@ design/rpfl_back.sv @@
// back of the record pool: executes queued operations against the word store
`default_nettype none

module rpfl_back #(
  parameter int unsigned StoreWords = rpfl_pkg::StoreWordsDef,
  parameter int unsigned MaxFields  = rpfl_pkg::MaxFieldsDef,
  localparam int unsigned FieldCntW = $clog2(MaxFields + 1),
  localparam int unsigned SpanAw    = $clog2(rpfl_pkg::RecordLimit * MaxFields),
  localparam int unsigned RamAw     = $clog2(StoreWords),
  localparam int unsigned WordAw    = (SpanAw > RamAw) ? SpanAw : RamAw
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic [FieldCntW-1:0]        fields_i,
  input  wire logic                        op_valid_i,
  output logic                             op_ready_o,
  input  wire rpfl_pkg::op_t               op_i,
  input  wire logic [WordAw-1:0]           op_addr_i,
  rpfl_rsp_if.source                       rsp_o,
  output logic                             ram_we_o,
  output logic      [RamAw-1:0]            ram_addr_o,
  output logic      [rpfl_pkg::ValueW-1:0] ram_wdata_o,
  input  wire logic [rpfl_pkg::ValueW-1:0] ram_rdata_i
);
  import rpfl_pkg::*;

  localparam int unsigned NeedW = CountW + FieldCntW;

  back_state_e       state_q, state_d;
  logic [CountW-1:0] total_q, total_d;
  logic [IdxW-1:0]   head_q, head_d;
  logic              head_valid_q, head_valid_d;
  logic              rd_in_store_q, rd_in_store_d;
  logic              res_valid_q, res_valid_d;
  logic [ValueW-1:0] rv_q, rv_d;
  logic [IdxW-1:0]   slot_q, slot_d;
  status_e           status_q, status_d;

  logic              load, out_free, ri_ok, full, head_in_store;
  logic [WordAw-1:0] head_addr;
  logic [NeedW-1:0]  need;
  logic [ValueW-1:0] link;

  always_comb begin
    out_free      = !res_valid_q || rsp_o.ready;
    head_addr     = WordAw'(head_q) * WordAw'(fields_i);
    head_in_store = 32'(head_addr) < StoreWords;
    need          = NeedW'(total_q + CountW'(1)) * NeedW'(fields_i);
    full          = (32'(total_q) + 1 > RecordLimit) || (32'(need) > StoreWords);
    ri_ok         = {1'b0, op_i.record_index} < total_q;
    link          = rd_in_store_q ? ram_rdata_i : '0;
  end

  always_comb begin
    state_d       = state_q;
    total_d       = total_q;
    head_d        = head_q;
    head_valid_d  = head_valid_q;
    rd_in_store_d = rd_in_store_q;
    res_valid_d   = res_valid_q && !rsp_o.ready;
    op_ready_o    = 1'b0;
    ram_we_o      = 1'b0;
    ram_addr_o    = op_addr_i[RamAw-1:0];
    ram_wdata_o   = op_i.write_value;
    load          = 1'b0;
    rv_d          = '0;
    slot_d        = '0;
    status_d      = STATUS_OK;

    case (state_q)
      ST_EXEC: begin
        if (op_valid_i && out_free) begin
          op_ready_o = 1'b1;
          case (op_i.mode)
            MODE_GET: begin
              if (ri_ok && op_i.field_ok) begin
                rd_in_store_d = op_i.in_store;
                state_d       = ST_READ;
              end else begin
                load     = 1'b1;
                status_d = STATUS_BAD;
              end
            end
            MODE_SET: begin
              load = 1'b1;
              if (ri_ok && op_i.field_ok) begin
                ram_we_o = op_i.in_store;
              end else begin
                status_d = STATUS_BAD;
              end
            end
            MODE_PUSH_BACK, MODE_INSERT: begin
              if (op_i.mode == MODE_INSERT && head_valid_q) begin
                ram_addr_o    = head_addr[RamAw-1:0];
                rd_in_store_d = head_in_store;
                state_d       = ST_LINK;
              end else begin
                load = 1'b1;
                if (full) begin
                  status_d = STATUS_FULL;
                end else begin
                  slot_d  = total_q[IdxW-1:0];
                  total_d = total_q + CountW'(1);
                end
              end
            end
            MODE_POP_BACK: begin
              load = 1'b1;
              if (total_q != '0) begin
                total_d = total_q - CountW'(1);
              end else begin
                status_d = STATUS_BAD;
              end
            end
            MODE_ERASE: begin
              load = 1'b1;
              if (ri_ok) begin
                ram_we_o     = op_i.in_store;
                ram_wdata_o  = head_valid_q ? ValueW'(head_q) : '1;
                head_d       = op_i.record_index;
                head_valid_d = 1'b1;
              end else begin
                status_d = STATUS_BAD;
              end
            end
            MODE_CLEAR: begin
              load         = 1'b1;
              total_d      = '0;
              head_d       = '0;
              head_valid_d = 1'b0;
            end
            default: begin
              load     = 1'b1;
              status_d = STATUS_BAD;
            end
          endcase
        end
      end
      ST_READ: begin
        load    = 1'b1;
        rv_d    = link;
        state_d = ST_EXEC;
      end
      ST_LINK: begin
        load   = 1'b1;
        slot_d = head_q;
        if (link[ValueW-1:IdxW] == '0) begin
          head_d = link[IdxW-1:0];
        end else begin
          head_d       = '0;
          head_valid_d = 1'b0;
        end
        state_d = ST_EXEC;
      end
      default: begin
        state_d = ST_EXEC;
      end
    endcase

    if (load) begin
      res_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_EXEC;
      total_q       <= '0;
      head_q        <= '0;
      head_valid_q  <= 1'b0;
      rd_in_store_q <= 1'b0;
      res_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      total_q       <= total_d;
      head_q        <= head_d;
      head_valid_q  <= head_valid_d;
      rd_in_store_q <= rd_in_store_d;
      res_valid_q   <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      rv_q     <= rv_d;
      slot_q   <= slot_d;
      status_q <= status_d;
    end
  end

  assign rsp_o.valid        = res_valid_q;
  assign rsp_o.read_value   = rv_q;
  assign rsp_o.slot         = slot_q;
  assign rsp_o.record_count = total_q;
  assign rsp_o.status       = status_q;

endmodule

`default_nettype wire
